// ===== rtl/cordic_sine_cosine_defines.svh =====
// assertion macros shared by the cordic sine/cosine rtl
`ifndef CORDIC_SINE_COSINE_DEFINES_SVH
`define CORDIC_SINE_COSINE_DEFINES_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define CSC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("csc assertion failed");
// condition implies consequence in the next cycle
`define CSC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CSC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/csc_pkg.sv =====
// types, constants and the arctangent table of the cordic sine/cosine block
`timescale 1ns / 1ps

package csc_pkg;

    // datapath word for the rotating vector, angle accumulator and target
    localparam int WORD_W = 18;
    typedef logic signed [WORD_W-1:0] csc_word_t;

    // angle wrap: offset is a multiple of a full turn that makes the angle positive
    localparam int          FULL_TURN    = 360;
    localparam int          HALF_TURN    = 180;
    localparam int          QUARTER_TURN = 90;
    localparam int          EIGHTH_TURN  = 45;
    localparam logic [16:0] WRAP_OFFSET  = 17'd33120;
    localparam logic [15:0] WRAP_RECIP   = 16'd46604;
    localparam int          WRAP_SHIFT   = 24;

    // scaling of 0..45 degrees so that 45 degrees maps to 0x4000
    localparam logic [20:0] SCALE_RECIP  = 21'd1491309;
    localparam int          SCALE_SHIFT  = 16;

    // gain-compensated starting x value
    localparam csc_word_t   START_GAIN   = 18'sh04DBA;

    // quadrant fold applied before rotation
    typedef enum logic [1:0] {
        QTR_NONE,
        QTR_POS,
        QTR_NEG
    } csc_quarter_t;

    // control that travels with each item down the chain
    typedef struct packed {
        logic         valid;
        logic         half_neg;
        csc_quarter_t quarter;
    } csc_tag_t;

    // vector state of one item
    typedef struct packed {
        csc_word_t c;
        csc_word_t s;
        csc_word_t acc;
        csc_word_t target;
    } csc_vec_t;

    // arctangent of 2^-i, 45 degrees = 0x4000
    function automatic csc_word_t arc_angle(input logic [3:0] idx);
        csc_word_t v;
        case (idx)
            4'd0:    v = 18'sh04000;
            4'd1:    v = 18'sh025C8;
            4'd2:    v = 18'sh013F6;
            4'd3:    v = 18'sh00A22;
            4'd4:    v = 18'sh00516;
            4'd5:    v = 18'sh0028B;
            4'd6:    v = 18'sh00145;
            4'd7:    v = 18'sh000A2;
            4'd8:    v = 18'sh00051;
            4'd9:    v = 18'sh00029;
            4'd10:   v = 18'sh00014;
            4'd11:   v = 18'sh0000A;
            4'd12:   v = 18'sh00005;
            4'd13:   v = 18'sh00003;
            4'd14:   v = 18'sh00002;
            default: v = 18'sh00001;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/csc_prep.sv =====
// front end: wraps, folds and scales the angle in four pipeline stages
`timescale 1ns / 1ps
`include "cordic_sine_cosine_defines.svh"

module csc_prep
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [15:0]   angle_degrees,
    output csc_pkg::csc_tag_t    tag_out,
    output csc_pkg::csc_vec_t    vec_out
);

    // stage 1: offset angle and reciprocal quotient by a full turn
    logic [16:0] s1_u;
    logic [32:0] s1_prod;
    logic        s1_valid_reg;
    logic [16:0] s1_u_reg;
    logic [8:0]  s1_q_reg;

    // stage 2: remainder and wrap into -180..180
    logic [16:0]       s2_qx;
    logic [8:0]        s2_rem;
    logic signed [8:0] s2_wrap;
    logic              s2_valid_reg;
    logic signed [8:0] s2_ang_reg;

    // stage 3: half-plane and quadrant fold
    logic signed [8:0]     s3_half;
    logic signed [8:0]     s3_fold;
    logic                  s3_half_neg;
    csc_pkg::csc_quarter_t s3_quarter;
    logic                  s3_valid_reg;
    logic signed [6:0]     s3_ang_reg;
    logic                  s3_half_neg_reg;
    csc_pkg::csc_quarter_t s3_quarter_reg;

    // stage 4: scale to 45 degrees = 0x4000 and apply sign
    logic [5:0]            s4_mag;
    logic [26:0]           s4_prod;
    logic [14:0]           s4_scaled;
    csc_pkg::csc_word_t    s4_target;
    logic                  s4_valid_reg;
    csc_pkg::csc_word_t    s4_target_reg;
    logic                  s4_half_neg_reg;
    csc_pkg::csc_quarter_t s4_quarter_reg;

    // stage 1 datapath
    assign s1_u    = 17'(int'(angle_degrees) + int'(csc_pkg::WRAP_OFFSET));
    assign s1_prod = 33'(s1_u) * 33'(csc_pkg::WRAP_RECIP);

    // stage 2 datapath
    always_comb
    begin
        s2_qx  = 17'(s1_q_reg) * 17'(csc_pkg::FULL_TURN);
        s2_rem = 9'(s1_u_reg - s2_qx);
        if (s2_rem > 9'(csc_pkg::HALF_TURN))
        begin
            s2_wrap = 9'(int'(s2_rem) - csc_pkg::FULL_TURN);
        end
        else
        begin
            s2_wrap = $signed(s2_rem);
        end
    end

    // stage 3 datapath
    always_comb
    begin
        if (s2_ang_reg < -9'sd90)
        begin
            s3_half     = s2_ang_reg + 9'(csc_pkg::HALF_TURN);
            s3_half_neg = 1'b1;
        end
        else if (s2_ang_reg > 9'sd90)
        begin
            s3_half     = s2_ang_reg - 9'(csc_pkg::HALF_TURN);
            s3_half_neg = 1'b1;
        end
        else
        begin
            s3_half     = s2_ang_reg;
            s3_half_neg = 1'b0;
        end

        if (s3_half < -9'sd45)
        begin
            s3_fold    = s3_half + 9'(csc_pkg::QUARTER_TURN);
            s3_quarter = csc_pkg::QTR_NEG;
        end
        else if (s3_half > 9'sd45)
        begin
            s3_fold    = s3_half - 9'(csc_pkg::QUARTER_TURN);
            s3_quarter = csc_pkg::QTR_POS;
        end
        else
        begin
            s3_fold    = s3_half;
            s3_quarter = csc_pkg::QTR_NONE;
        end
    end

    // stage 4 datapath: (mag << 10) / 45 by reciprocal, then << 4
    always_comb
    begin
        s4_mag    = s3_ang_reg[6] ? 6'(-s3_ang_reg) : 6'(s3_ang_reg);
        s4_prod   = 27'(s4_mag) * 27'(csc_pkg::SCALE_RECIP);
        s4_scaled = {s4_prod[csc_pkg::SCALE_SHIFT +: 11], 4'b0000};
        if (s3_ang_reg[6])
        begin
            s4_target = -$signed({3'b000, s4_scaled});
        end
        else
        begin
            s4_target = $signed({3'b000, s4_scaled});
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_u_reg        <= s1_u;
            s1_q_reg        <= s1_prod[csc_pkg::WRAP_SHIFT +: 9];
            s2_ang_reg      <= s2_wrap;
            s3_ang_reg      <= 7'(s3_fold);
            s3_half_neg_reg <= s3_half_neg;
            s3_quarter_reg  <= s3_quarter;
            s4_target_reg   <= s4_target;
            s4_half_neg_reg <= s3_half_neg_reg;
            s4_quarter_reg  <= s3_quarter_reg;
        end
    end

    // hand-off to the first rotation cell
    always_comb
    begin
        tag_out.valid    = s4_valid_reg;
        tag_out.half_neg = s4_half_neg_reg;
        tag_out.quarter  = s4_quarter_reg;
        vec_out.c        = csc_pkg::START_GAIN;
        vec_out.s        = '0;
        vec_out.acc      = '0;
        vec_out.target   = s4_target_reg;
    end

    // wrapped angle stays within half a turn
    `CSC_ASSERT_IMP(a_wrap_range, clk, rst_n, s2_valid_reg,
        (s2_ang_reg >= -9'sd180) && (s2_ang_reg <= 9'sd180))
    // folded angle stays within an eighth of a turn
    `CSC_ASSERT_IMP(a_fold_range, clk, rst_n, s3_valid_reg,
        (s3_ang_reg >= -7'sd45) && (s3_ang_reg <= 7'sd45))
    // scaled target never exceeds 0x4000 in magnitude
    `CSC_ASSERT_IMP(a_target_range, clk, rst_n, s4_valid_reg,
        (s4_target_reg >= -18'sd16384) && (s4_target_reg <= 18'sd16384))

endmodule

// ===== rtl/csc_cell.sv =====
// one cordic micro-rotation cell of the rotation chain
`timescale 1ns / 1ps

module csc_cell
#(
    parameter int STAGE_INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [4:0]        steps,
    input  csc_pkg::csc_tag_t tag_in,
    input  csc_pkg::csc_vec_t vec_in,
    output csc_pkg::csc_tag_t tag_out,
    output csc_pkg::csc_vec_t vec_out
);

    csc_pkg::csc_word_t c_sh;
    csc_pkg::csc_word_t s_sh;
    csc_pkg::csc_word_t arc;
    csc_pkg::csc_vec_t  vec_next;
    csc_pkg::csc_tag_t  tag_reg;
    csc_pkg::csc_vec_t  vec_reg;

    // rotate toward the target when this cell is enabled, else pass through
    always_comb
    begin
        c_sh     = $signed(vec_in.c) >>> STAGE_INDEX;
        s_sh     = $signed(vec_in.s) >>> STAGE_INDEX;
        arc      = csc_pkg::arc_angle(4'(STAGE_INDEX));
        vec_next = vec_in;
        if (5'(STAGE_INDEX) < steps)
        begin
            if ($signed(vec_in.target) < $signed(vec_in.acc))
            begin
                vec_next.c   = vec_in.c + s_sh;
                vec_next.s   = vec_in.s - c_sh;
                vec_next.acc = vec_in.acc - arc;
            end
            else
            begin
                vec_next.c   = vec_in.c - s_sh;
                vec_next.s   = vec_in.s + c_sh;
                vec_next.acc = vec_in.acc + arc;
            end
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (adv)
        begin
            tag_reg <= tag_in;
        end
    end

    // vector register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign tag_out = tag_reg;
    assign vec_out = vec_reg;

endmodule

// ===== rtl/csc_out.sv =====
// quadrant and half-plane correction, output register and skid buffer
`timescale 1ns / 1ps
`include "cordic_sine_cosine_defines.svh"

module csc_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  csc_pkg::csc_tag_t tag_in,
    input  csc_pkg::csc_vec_t vec_in,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [16:0]       sine_value,
    output logic [16:0]       cosine_value
);

    csc_pkg::csc_word_t c_abs;
    csc_pkg::csc_word_t sin_q;
    csc_pkg::csc_word_t cos_q;
    csc_pkg::csc_word_t sin_fix;
    csc_pkg::csc_word_t cos_fix;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        out_load;
    logic        skid_load;
    logic        skid_drain;
    logic [16:0] out_sin_reg;
    logic [16:0] out_cos_reg;
    logic [16:0] skid_sin_reg;
    logic [16:0] skid_cos_reg;

    // cosine made non-negative, then quadrant swap and half-plane negate
    always_comb
    begin
        c_abs = ($signed(vec_in.c) < 0) ? -vec_in.c : vec_in.c;
        case (tag_in.quarter)
            csc_pkg::QTR_POS:
            begin
                sin_q = c_abs;
                cos_q = -vec_in.s;
            end
            csc_pkg::QTR_NEG:
            begin
                sin_q = -c_abs;
                cos_q = vec_in.s;
            end
            default:
            begin
                sin_q = vec_in.s;
                cos_q = c_abs;
            end
        endcase
        sin_fix = tag_in.half_neg ? -sin_q : sin_q;
        cos_fix = tag_in.half_neg ? -cos_q : cos_q;
    end

    // pipeline advances while the skid stage is empty
    assign adv = !skid_valid_reg;

    // output and skid control
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        skid_drain      = 1'b0;
        if (!skid_valid_reg)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = tag_in.valid;
                out_load       = tag_in.valid;
            end
            else if (tag_in.valid)
            begin
                skid_valid_next = 1'b1;
                skid_load       = 1'b1;
            end
        end
        else if (out_ready)
        begin
            skid_valid_next = 1'b0;
            skid_drain      = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sin_reg <= sin_fix[16:0];
            out_cos_reg <= cos_fix[16:0];
        end
        else if (skid_drain)
        begin
            out_sin_reg <= skid_sin_reg;
            out_cos_reg <= skid_cos_reg;
        end
        if (skid_load)
        begin
            skid_sin_reg <= sin_fix[16:0];
            skid_cos_reg <= cos_fix[16:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign sine_value   = out_sin_reg;
    assign cosine_value = out_cos_reg;

    // skid stage only fills behind a waiting result
    `CSC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // a full skid stage holds until the output transfer happens
    `CSC_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_valid_reg && !out_ready,
        skid_valid_reg)
    // a new result arriving while the result is stalled fills the skid stage
    `CSC_ASSERT_NXT(a_skid_fill_stall, clk, rst_n,
        !skid_valid_reg && out_valid_reg && !out_ready && tag_in.valid,
        skid_valid_reg && out_valid_reg)

endmodule

// ===== rtl/cordic_sine_cosine.sv =====
// cordic sine/cosine: an accepted angle is registered through these stages in order:
// four front-end stages wrap, fold and scale the angle, one cell per micro-rotation
// follows, then a correction and output register stage
// throughput one angle per cycle while results are taken; a stalled result lets one
// more angle into the skid stage, then input waits until the skid stage drains
// rst_n clears all valid flags and sets rotation_count to 12; no clearing pass
`timescale 1ns / 1ps

module cordic_sine_cosine
#(
    parameter int MAX_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: rotation_count
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] angle_degrees
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [16:0] sine_value, [33:17] cosine_value
);

    localparam logic [4:0] STAGE_LIMIT = 5'(MAX_STAGES);

    logic [4:0]        count_reg;
    logic [4:0]        steps;
    logic              adv;
    logic [16:0]       sine_value;
    logic [16:0]       cosine_value;
    csc_pkg::csc_tag_t tag [0:MAX_STAGES];
    csc_pkg::csc_vec_t vec [0:MAX_STAGES];

    // rotation count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd12;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // clamp the rotation count to the number of cells
    assign steps = (count_reg > STAGE_LIMIT) ? STAGE_LIMIT : count_reg;

    // input transfer accepted whenever the pipeline can move
    assign s_axis_tready = adv;

    csc_prep u_prep
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (s_axis_tvalid),
        .angle_degrees ($signed(s_axis_tdata)),
        .tag_out       (tag[0]),
        .vec_out       (vec[0])
    );

    // chain of rotation cells
    for (genvar g = 0; g < MAX_STAGES; g++)
    begin : g_cell
        csc_cell
        #(
            .STAGE_INDEX (g)
        )
        u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .steps   (steps),
            .tag_in  (tag[g]),
            .vec_in  (vec[g]),
            .tag_out (tag[g+1]),
            .vec_out (vec[g+1])
        );
    end

    csc_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag_in       (tag[MAX_STAGES]),
        .vec_in       (vec[MAX_STAGES]),
        .adv          (adv),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

    assign m_axis_tdata = {6'b000000, cosine_value, sine_value};

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the cordic sine/cosine streaming block
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_ROTATIONS  = 16;
    localparam int PIPE_LATENCY   = MAX_ROTATIONS + 5;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 10;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 180;
    localparam int LONG_HOLD      = 300;

    // arctangent of 2^-i with 45 degrees at 0x4000
    localparam int ATAN_STEP [16] = '{
        'h4000, 'h25C8, 'h13F6, 'h0A22, 'h0516, 'h028B, 'h0145, 'h00A2,
        'h0051, 'h0029, 'h0014, 'h000A, 'h0005, 'h0003, 'h0002, 'h0001
    };

    // field extremes, fold boundaries and wraps
    localparam int DIRECTED_ANGLES [25] = '{
        0, 1, -1, 44, 45, 46, -44, -45, -46, 89, 90, 91, -89, -90, -91,
        135, -135, 179, 180, -180, 181, 360, -360, 32767, -32768
    };

    typedef struct packed {
        logic [16:0] sine;
        logic [16:0] cosine;
    } trig_pair_t;

    // scoreboard: predicts sine/cosine per accepted angle and checks results in order
    class trig_scoreboard;
        trig_pair_t pending_pairs[$];
        int         rotations;
        int         errors;

        function new();
            rotations = 12;
            errors    = 0;
        endfunction

        function void set_rotations(logic [4:0] value);
            rotations = int'(value);
        endfunction

        function int pending_count();
            return pending_pairs.size();
        endfunction

        function trig_pair_t sine_cosine_of(logic [15:0] angle_bits);
            int                    deg;
            int                    mag;
            int                    target;
            int                    x;
            int                    y;
            int                    acc;
            int                    nx;
            int                    stages;
            int                    sin_v;
            int                    cos_v;
            logic                  half_neg;
            csc_pkg::csc_quarter_t quarter;
            trig_pair_t            pair;
            deg = $signed(angle_bits);
            // wrap into -180..180
            deg = deg % 360;
            if (deg < 0)
                deg += 360;
            if (deg > 180)
                deg -= 360;
            // half-plane fold
            half_neg = 1'b1;
            if (deg < -90)
                deg += 180;
            else if (deg > 90)
                deg -= 180;
            else
                half_neg = 1'b0;
            // quadrant fold
            if (deg < -45)
            begin
                deg += 90;
                quarter = csc_pkg::QTR_NEG;
            end
            else if (deg > 45)
            begin
                deg -= 90;
                quarter = csc_pkg::QTR_POS;
            end
            else
                quarter = csc_pkg::QTR_NONE;
            // scale magnitude, then apply sign
            mag    = (deg < 0) ? -deg : deg;
            mag    = ((mag << 10) / 45) << 4;
            target = (deg < 0) ? -mag : mag;
            stages = (rotations > MAX_ROTATIONS) ? MAX_ROTATIONS : rotations;
            // micro-rotations
            x   = csc_pkg::START_GAIN;
            y   = 0;
            acc = 0;
            for (int i = 0; i < stages; i++)
            begin
                if (target < acc)
                begin
                    nx  = x + (y >>> i);
                    y   = y - (x >>> i);
                    acc = acc - ATAN_STEP[i];
                end
                else
                begin
                    nx  = x - (y >>> i);
                    y   = y + (x >>> i);
                    acc = acc + ATAN_STEP[i];
                end
                x = nx;
            end
            if (x < 0)
                x = -x;
            // undo the folds
            case (quarter)
                csc_pkg::QTR_POS:
                begin
                    sin_v = x;
                    cos_v = -y;
                end
                csc_pkg::QTR_NEG:
                begin
                    sin_v = -x;
                    cos_v = y;
                end
                default:
                begin
                    sin_v = y;
                    cos_v = x;
                end
            endcase
            if (half_neg)
            begin
                sin_v = -sin_v;
                cos_v = -cos_v;
            end
            pair.sine   = sin_v[16:0];
            pair.cosine = cos_v[16:0];
            return pair;
        endfunction

        function void note_angle(logic [15:0] angle_bits);
            pending_pairs.push_back(sine_cosine_of(angle_bits));
        endfunction

        function void report(string what, logic [16:0] want, logic [16:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what,
                $signed(want), $signed(got));
        endfunction

        function void check_result(logic [39:0] word);
            trig_pair_t want;
            if (pending_pairs.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with no angle pending, actual %h",
                    $time, word);
                return;
            end
            want = pending_pairs.pop_front();
            if (word[16:0] !== want.sine)
                report("sine", want.sine, word[16:0]);
            if (word[33:17] !== want.cosine)
                report("cosine", want.cosine, word[33:17]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] angle_degrees
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [16:0] sine_value, [33:17] cosine_value

    trig_scoreboard trig_board;
    int             rx_hold_cycles;
    logic           tx_burst;
    int             idle_cycles = 0;

    cordic_sine_cosine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[cordic_sine_cosine] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls, burst stretches and one long hold-off
    initial
    begin
        int   stall;
        int   taken;
        logic rx_burst;
        logic hold_done;
        taken         = 0;
        rx_burst      = 1'b0;
        hold_done     = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (rx_hold_cycles > 0 && !hold_done)
            begin
                stall     = rx_hold_cycles;
                hold_done = 1'b1;
            end
            else
                stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            trig_board.check_result(m_axis_tdata);
            taken++;
        end
    end

    // offer one angle after a random gap and wait for its transfer
    task automatic send_angle(input logic [15:0] angle);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        trig_board.note_angle(angle);
    endtask

    // stop offering and let every pending result drain
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (trig_board.pending_count() != 0)
            @(posedge clk);
    endtask

    // write rotation_count once the pipeline is empty
    task automatic write_rotations(input logic [4:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        trig_board.set_rotations(value);
    endtask

    // random angle: full range, near range, or near a fold boundary
    function automatic logic [15:0] random_angle();
        int pick;
        int deg;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            deg = $urandom_range(0, 65535);
        else if (pick < 7)
            deg = $urandom_range(0, 1440) - 720;
        else
            deg = 45 * ($urandom_range(0, 16) - 8) + $urandom_range(0, 2) - 1
                + 360 * ($urandom_range(0, 180) - 90);
        return deg[15:0];
    endfunction

    // stimulus
    initial
    begin
        int phase_rot [7];
        trig_board     = new();
        rx_hold_cycles = 0;
        tx_burst       = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed angles at the reset rotation count
        foreach (DIRECTED_ANGLES[k])
            send_angle(DIRECTED_ANGLES[k][15:0]);

        // random phases over several rotation counts, extremes included
        phase_rot = '{0, 1, 16, 31, 17, 8, 0};
        phase_rot[6] = $urandom_range(0, 31);
        foreach (phase_rot[p])
        begin
            write_rotations(phase_rot[p][4:0]);
            if (p == 2)
                rx_hold_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_angle(random_angle());
            end
        end

        // wait for the tail, then a settling pause
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (trig_board.errors == 0 && trig_board.pending_count() == 0)
            $display("[cordic_sine_cosine] OK");
        else
            $display("[cordic_sine_cosine] ERROR");
        $finish;
    end

endmodule

// ===== cordic_sine_cosine.f =====
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_prep.sv
rtl/csc_cell.sv
rtl/csc_out.sv
rtl/cordic_sine_cosine.sv
tb/sv/testbench.sv
